>>> src/rpwb_pkg.sv
// ----------------------------------------------------------------------------
// rpwb_pkg
// shared types and constants for the reference patch white balance
// ----------------------------------------------------------------------------
package rpwb_pkg;

  localparam int HISTORY_DEPTH  = 30;
  localparam int MAX_DIM        = 4096;
  localparam int GAIN_FRAC_BITS = 12;
  localparam int TINT_FRAC      = 14;
  localparam int NUM_CH         = 3;

  localparam int SUM_W   = 33;
  localparam int CNT_W   = 25;
  localparam int GAIN_W  = 20;
  localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
  localparam int FILL_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int ACC_W   = GAIN_W + FILL_W;
  // dividend of the gain division: grey(8) * tint(16) << frac
  localparam int DIVD_W  = 8 + 16 + GAIN_FRAC_BITS;

  localparam logic [7:0]        VALID_LIMIT = 8'd253;
  localparam logic [7:0]        PIX_MAX     = 8'd255;
  localparam logic [GAIN_W-1:0] GAIN_MAX    = '1;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = '1;
  localparam logic [GAIN_W-1:0] GAIN_UNITY  = GAIN_W'(1 << GAIN_FRAC_BITS);
  localparam logic [12:0]       DIM_LIMIT   = 13'(MAX_DIM);
  // x * 683 >> 11 equals x / 3 for x below 2048
  localparam logic [10:0]       THIRD_RECIP = 11'd683;

  typedef enum logic [2:0] {
    REG_ROW_START = 3'd0,
    REG_ROW_END   = 3'd1,
    REG_COL_START = 3'd2,
    REG_COL_END   = 3'd3,
    REG_SAT_HIGH  = 3'd4,
    REG_SAT_LOW   = 3'd5,
    REG_TINT      = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_MEAN,
    ST_GREY,
    ST_GAIN,
    ST_AVG,
    ST_DIV_AVG
  } state_t;

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_GAIN = 2'd1,
    DIV_AVG  = 2'd2
  } div_op_t;

  typedef struct packed {
    logic        kind;
    logic [11:0] row;
    logic [11:0] col;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        pass_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       held_saturated;
    logic       frame_end;
  } out_item_t;

  // control from the sequencer to the per-channel lanes
  typedef struct packed {
    logic    accum;
    logic    clear;
    div_op_t div_op;
    logic    div_start;
    logic    mean_take;
    logic    gain_take;
    logic    hist_write;
    logic    avg_clear;
    logic    avg_step;
    logic    avg_take;
  } lane_ctrl_t;

endpackage

>>> src/rpwb_div.sv
// ----------------------------------------------------------------------------
// rpwb_div
// radix-2 restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module rpwb_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rpwb_pkg::DIVD_W-1:0] dividend,
  input  logic [rpwb_pkg::DIVD_W-1:0] divisor,
  output logic                        busy,
  output logic [rpwb_pkg::DIVD_W-1:0] quotient
);
  import rpwb_pkg::*;

  localparam int STEP_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] rem;
  logic [DIVD_W-1:0] dvs;
  logic [STEP_W-1:0] steps;
  logic [DIVD_W:0]   trial;

  assign trial = {rem, quotient[DIVD_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps    <= STEP_W'(DIVD_W);
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (steps != '0) begin
      steps <= steps - 1'b1;
      if (!trial[DIVD_W]) begin
        rem      <= trial[DIVD_W-1:0];
        quotient <= {quotient[DIVD_W-2:0], 1'b1};
      end else begin
        rem      <= {rem[DIVD_W-2:0], quotient[DIVD_W-1]};
        quotient <= {quotient[DIVD_W-2:0], 1'b0};
      end
    end
  end

  assign busy = (steps != '0);

endmodule

>>> src/rpwb_lane.sv
// ----------------------------------------------------------------------------
// rpwb_lane
// one color channel: patch sum, mean and gain division, gain history, scaling
// ----------------------------------------------------------------------------
module rpwb_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  rpwb_pkg::lane_ctrl_t        ctrl,
  input  logic [7:0]                  pix,
  input  logic [rpwb_pkg::CNT_W-1:0]  count,
  input  logic [7:0]                  grey,
  input  logic [15:0]                 tint,
  input  logic [rpwb_pkg::SLOT_W-1:0] slot,
  input  logic [rpwb_pkg::SLOT_W-1:0] avg_idx,
  input  logic [rpwb_pkg::FILL_W-1:0] filled,
  output logic                        div_busy,
  output logic [7:0]                  mean,
  output logic [7:0]                  scaled
);
  import rpwb_pkg::*;

  logic [SUM_W-1:0]  sum;
  logic [DIVD_W-1:0] divd, divs, quo;
  logic [GAIN_W-1:0] hist [HISTORY_DEPTH];
  logic [GAIN_W-1:0] hist_rd;
  logic [ACC_W-1:0]  acc;
  logic [GAIN_W-1:0] gain;
  logic [GAIN_W-1:0] new_gain;
  logic [GAIN_W+7:0] prod;

  // the divider serves the mean, the gain and the history average in turn
  always_comb begin
    case (ctrl.div_op)
      DIV_MEAN: begin
        divd = DIVD_W'(sum) + DIVD_W'(count >> 1);
        divs = DIVD_W'(count);
      end
      DIV_GAIN: begin
        divd = DIVD_W'({8'd0, grey} * {8'd0, tint}) << GAIN_FRAC_BITS;
        divs = DIVD_W'(mean) << TINT_FRAC;
      end
      DIV_AVG: begin
        divd = DIVD_W'(acc);
        divs = DIVD_W'(filled);
      end
      default: begin
        divd = '0;
        divs = '0;
      end
    endcase
  end

  rpwb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (divd),
    .divisor  (divs),
    .busy     (div_busy),
    .quotient (quo)
  );

  always_comb begin
    if (mean == 8'd0 || quo > DIVD_W'(GAIN_MAX)) begin
      new_gain = GAIN_MAX;
    end else begin
      new_gain = quo[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum  <= '0;
      gain <= GAIN_UNITY;
    end else begin
      if (ctrl.clear) begin
        sum <= '0;
      end else if (ctrl.accum) begin
        sum <= sum + SUM_W'(pix);
      end
      if (ctrl.avg_take) begin
        gain <= quo[GAIN_W-1:0];
      end
    end
  end

  // mean fits 8 bits because it is below 253
  always_ff @(posedge clk) begin
    if (ctrl.mean_take) begin
      mean <= quo[7:0];
    end
    if (ctrl.avg_clear) begin
      acc <= '0;
    end else if (ctrl.avg_step) begin
      acc <= acc + ACC_W'(hist_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.hist_write) begin
      hist[slot] <= new_gain;
    end
    hist_rd <= hist[avg_idx];
  end

  assign prod   = {8'd0, gain} * {{GAIN_W{1'b0}}, pix};
  assign scaled = (prod[GAIN_W+7:GAIN_FRAC_BITS] > (GAIN_W+8-GAIN_FRAC_BITS)'(PIX_MAX))
                  ? PIX_MAX : prod[GAIN_FRAC_BITS+7:GAIN_FRAC_BITS];

endmodule

>>> src/reference_patch_white_balance_unit.sv
// ----------------------------------------------------------------------------
// reference_patch_white_balance_unit
// grey world white balance measured over a reference rectangle
// ----------------------------------------------------------------------------
// Pixels are taken one per cycle in both passes while the unit is in its run
// state and the output is not stalled; a corrected pixel appears in the cycle
// after it is taken, through an output register. The last pixel of a measure
// pass starts the gain update if any patch pixel was counted: a mean division,
// a grey step, a gain division, a history sum over the filled entries (one
// history read per cycle, up to 30 entries) and an average division. Each
// division runs 36 steps on a divider per channel; no pixel is taken during the update.
module reference_patch_white_balance_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rpwb_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rpwb_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [47:0]          cfg_data
);
  import rpwb_pkg::*;

  logic [12:0] row_start, row_end, col_start, col_end;
  logic [7:0]  sat_high, sat_low;
  logic [47:0] tint_factors;

  state_t state, state_next;
  logic [CNT_W-1:0]  count;
  logic [SLOT_W-1:0] slot, avg_idx;
  logic [FILL_W-1:0] filled;
  logic [FILL_W-1:0] avg_cnt;
  logic [7:0]        grey;
  logic              phase;
  lane_ctrl_t        ctrl;
  logic [NUM_CH-1:0] busy;
  logic [7:0]        mean [NUM_CH];
  logic [7:0]        scaled [NUM_CH];
  logic [7:0]        pix [NUM_CH];
  logic [15:0]       tint [NUM_CH];

  logic take, in_rect, counts, any_high, any_low, held;
  logic [12:0] row_lim, col_lim;
  logic [9:0]  mean_sum;
  logic [20:0] grey_prod;

  assign cfg_ready = 1'b1;
  assign take      = in_valid && !in_stall;
  assign in_stall  = (state != ST_RUN) || (out_valid && out_stall);

  assign pix[0]  = in_data.blue;
  assign pix[1]  = in_data.green;
  assign pix[2]  = in_data.red;
  assign tint[0] = tint_factors[47:32];
  assign tint[1] = tint_factors[31:16];
  assign tint[2] = tint_factors[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_start    <= 13'd240;
      row_end      <= 13'd312;
      col_start    <= 13'd601;
      col_end      <= 13'd640;
      sat_high     <= 8'd250;
      sat_low      <= 8'd200;
      tint_factors <= 48'd75296145423565;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_ROW_START: row_start    <= cfg_data[12:0];
        REG_ROW_END:   row_end      <= cfg_data[12:0];
        REG_COL_START: col_start    <= cfg_data[12:0];
        REG_COL_END:   col_end      <= cfg_data[12:0];
        REG_SAT_HIGH:  sat_high     <= cfg_data[7:0];
        REG_SAT_LOW:   sat_low      <= cfg_data[7:0];
        REG_TINT:      tint_factors <= cfg_data;
        default: ;
      endcase
    end
  end

  assign row_lim = (row_end > DIM_LIMIT) ? DIM_LIMIT : row_end;
  assign col_lim = (col_end > DIM_LIMIT) ? DIM_LIMIT : col_end;
  assign in_rect = ({1'b0, in_data.row} >= row_start) && ({1'b0, in_data.row} < row_lim)
                && ({1'b0, in_data.col} >= col_start) && ({1'b0, in_data.col} < col_lim);
  assign counts  = take && !in_data.kind && in_rect && in_data.blue < VALID_LIMIT
                && in_data.green < VALID_LIMIT && in_data.red < VALID_LIMIT
                && count != COUNT_MAX;
  assign mean_sum  = 10'(mean[0]) + 10'(mean[1]) + 10'(mean[2]);
  assign grey_prod = 21'(mean_sum) * 21'(THIRD_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_RUN;
      count  <= '0;
      slot   <= '0;
      filled <= '0;
      phase  <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.clear) begin
        count <= '0;
      end else if (counts) begin
        count <= count + 1'b1;
      end
      // phase marks that the divider was started in the current state
      if (state_next != state) begin
        phase <= 1'b0;
      end else if (ctrl.div_start) begin
        phase <= 1'b1;
      end
      if (ctrl.hist_write) begin
        slot   <= (slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot + 1'b1;
        if (filled != FILL_W'(HISTORY_DEPTH)) begin
          filled <= filled + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_GREY) begin
      grey <= grey_prod[18:11];
    end
    if (ctrl.avg_clear) begin
      avg_idx <= '0;
      avg_cnt <= '0;
    end else if (state == ST_AVG) begin
      avg_cnt <= avg_cnt + 1'b1;
      if (avg_idx != SLOT_W'(HISTORY_DEPTH - 1)) begin
        avg_idx <= avg_idx + 1'b1;
      end
    end
  end

  // hist read is registered, so each accumulation uses the entry indexed in the previous cycle
  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_RUN: begin
        ctrl.accum = counts;
        if (take && !in_data.kind && in_data.pass_end) begin
          if (count != '0 || counts) begin
            state_next = ST_MEAN;
          end else begin
            ctrl.clear = 1'b1;
          end
        end
      end
      ST_MEAN: begin
        ctrl.div_op = DIV_MEAN;
        if (!phase) begin
          ctrl.div_start = 1'b1;
        end else if (busy == '0) begin
          ctrl.mean_take = 1'b1;
          state_next     = ST_GREY;
        end
      end
      ST_GREY: begin
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        ctrl.div_op = DIV_GAIN;
        if (!phase) begin
          ctrl.div_start = 1'b1;
        end else if (busy == '0) begin
          ctrl.hist_write = 1'b1;
          ctrl.avg_clear  = 1'b1;
          state_next      = ST_AVG;
        end
      end
      ST_AVG: begin
        if (avg_cnt == filled + 1'b1) begin
          state_next = ST_DIV_AVG;
        end else if (avg_cnt != '0) begin
          ctrl.avg_step = 1'b1;
        end
      end
      ST_DIV_AVG: begin
        ctrl.div_op = DIV_AVG;
        if (!phase) begin
          ctrl.div_start = 1'b1;
        end else if (busy == '0) begin
          ctrl.avg_take = 1'b1;
          ctrl.clear    = 1'b1;
          state_next    = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    rpwb_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .pix      (pix[k]),
      .count    (count),
      .grey     (grey),
      .tint     (tint[k]),
      .slot     (slot),
      .avg_idx  (avg_idx),
      .filled   (filled),
      .div_busy (busy[k]),
      .mean     (mean[k]),
      .scaled   (scaled[k])
    );
  end

  assign any_high = (in_data.blue > sat_high) || (in_data.green > sat_high)
                 || (in_data.red > sat_high);
  assign any_low  = (in_data.blue < sat_low) || (in_data.green < sat_low)
                 || (in_data.red < sat_low);
  assign held     = any_high && !any_low;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= in_data.kind;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_data.kind) begin
      out_data.blue_out       <= held ? in_data.blue : scaled[0];
      out_data.green_out      <= held ? in_data.green : scaled[1];
      out_data.red_out        <= held ? in_data.red : scaled[2];
      out_data.held_saturated <= held;
      out_data.frame_end      <= in_data.pass_end;
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_RUN |-> !take) else $error("pixel taken during gain update");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    filled <= FILL_W'(HISTORY_DEPTH)) else $error("history fill overrun");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");

endmodule
